// File: hw/rtl/mtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared constants, types and the tempering function of the MT19937 word generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_W        = $clog2(STATE_WORDS);
  localparam int WORD_W       = 32;

  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'd2567483615;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;
  localparam logic [WORD_W-1:0] RESET_SEED   = 32'd19650218;
  localparam logic [WORD_W-1:0] UPPER_BIT    = 32'd2147483648;
  localparam logic [WORD_W-1:0] LOWER_BITS   = 32'd2147483647;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] FAR_WRAP = IDX_W'(STATE_WORDS - TWIST_OFFSET);
  localparam logic [IDX_W-1:0] FAR_OFS  = IDX_W'(TWIST_OFFSET);

  localparam logic CMD_RESEED = 1'b0;
  localparam logic CMD_DRAW   = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    word_t data;
  } mtg_wr_t;

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: hw/rtl/mersenne_twister_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 32-bit pseudo-random word generator with a memory-held state table.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall): cmd = 0 reseeds the table from
// seed_value and gives no result; cmd = 1 draws the next word.
// Response channel (rsp_valid/rsp_stall): one random_word per draw, in order.
// A draw twists its table word on the fly: the word after it and the word
// 397 places ahead are read from the two RAM read ports, the new word is
// written back and tempered into the output register.
// Draw: an accepted draw moves the FSM to its draw state, and the tempered word is
// registered into the output register once that register is free.
// Reseed: the seeder writes all 624 table words after the transfer (one table
// word per cycle through the seed multiplier); requests are stalled meanwhile.
// Reset: the table is seeded with 19650218 while req_stall is held high.
// A stalled response holds its word; a pending draw waits for the output
// register, and no further request is taken until it has moved on.
// ----------------------------------------------------------------------------
module mersenne_twister_generator (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  logic           cmd,
  input  mtg_pkg::word_t seed_value,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mtg_pkg::word_t random_word
);
  import mtg_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DRAW = 1'b1;

  logic     state;
  idx_t     index;
  word_t    cur;
  logic     seed_busy;
  logic     seed_start;
  mtg_wr_t  seed_wr;
  logic     req_take;
  logic     draw_done;
  idx_t     addr_next;
  idx_t     addr_far;
  word_t    rd_next;
  word_t    rd_far;
  word_t    y;
  word_t    twisted;
  logic     ram_we;
  idx_t     ram_waddr;
  word_t    ram_wdata;

  assign req_stall  = seed_busy || (state == ST_DRAW);
  assign req_take   = req_valid && !req_stall;
  assign seed_start = req_take && (cmd == CMD_RESEED);
  assign draw_done  = (state == ST_DRAW) && (!rsp_valid || !rsp_stall);

  assign addr_next = (index == LAST_IDX) ? '0 : index + 1'b1;
  assign addr_far  = (index < FAR_WRAP) ? index + FAR_OFS : index - FAR_WRAP;

  assign y       = (cur & UPPER_BIT) | (rd_next & LOWER_BITS);
  assign twisted = rd_far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);

  assign ram_we    = seed_wr.en || draw_done;
  assign ram_waddr = seed_wr.en ? seed_wr.addr : index;
  assign ram_wdata = seed_wr.en ? seed_wr.data : twisted;

  mtg_seeder u_seeder (
    .clk  (clk),
    .rst  (rst),
    .start(seed_start),
    .seed (seed_value),
    .busy (seed_busy),
    .wr   (seed_wr)
  );

  mtg_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STATE_WORDS)
  ) u_table (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr_a(addr_next),
    .rdata_a(rd_next),
    .raddr_b(addr_far),
    .rdata_b(rd_far)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      index     <= '0;
      cur       <= RESET_SEED;
      rsp_valid <= 1'b0;
    end else begin
      if (draw_done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (seed_start) begin
            index <= '0;
            cur   <= seed_value;
          end else if (req_take) begin
            state <= ST_DRAW;
          end
        end
        ST_DRAW: begin
          if (draw_done) begin
            state     <= ST_IDLE;
            cur       <= rd_next;
            index     <= addr_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (draw_done) begin
      random_word <= temper(twisted);
    end
  end

`ifndef NO_ASSERTIONS
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    index <= LAST_IDX)
    else $error("read index out of range");

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(seed_busy && state == ST_DRAW))
    else $error("draw in progress while table is being seeded");

  a_draw_follows: assert property (@(posedge clk) disable iff (rst)
    (req_take && cmd == CMD_DRAW) |=> (state == ST_DRAW))
    else $error("accepted draw did not start");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(draw_done))
    else $error("response raised without a finished draw");
`endif

endmodule

// File: hw/rtl/mtg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hw/rtl/mtg_seeder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_seeder
// Fills the state table from a seed, one word per cycle, with the
// multiplier recurrence. Starts on its own with the default seed at reset.
// ----------------------------------------------------------------------------
module mtg_seeder (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mtg_pkg::word_t  seed,
  output logic            busy,
  output mtg_pkg::mtg_wr_t wr
);
  import mtg_pkg::*;

  idx_t  cnt;
  word_t word;
  word_t mixed;
  word_t word_next;

  assign mixed     = word ^ (word >> 30);
  assign word_next = (mixed * SEED_MULT) + WORD_W'(cnt) + 32'd1;

  assign wr.en   = busy;
  assign wr.addr = cnt;
  assign wr.data = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
      word <= RESET_SEED;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      word <= seed;
    end else if (busy) begin
      word <= word_next;
      cnt  <= cnt + 1'b1;
      if (cnt == LAST_IDX) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
